>>> hw/rtl/minv_pkg.sv
// Package for the modular inverse block: payload structs, controller states,
// and the command/status structs between controller and datapath.
`default_nettype none
package minv_pkg;
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] modulus;
    } in_item_t;

    typedef struct packed {
        logic [31:0] inverse;
        logic        exists;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;        // capture operands
        logic div_start;   // load divider with r0 / r1 (or a / m)
        logic div_step;    // one restoring division step
        logic reduce_done; // r1 <= a mod m
        logic update;      // advance Euclid round with quotient
        logic finish;      // compute result
    } cmd_t;

    typedef struct packed {
        logic m_zero;
        logic r1_zero;
        logic div_last;
    } status_t;
endpackage
`default_nettype wire

>>> hw/rtl/minv_datapath.sv
// Datapath of the modular inverse block: Euclid registers and a shared
// bit-serial restoring divider. Depends on minv_pkg.
`default_nettype none
module minv_datapath (
    input  wire logic               clk,
    input  wire minv_pkg::in_item_t in_item,
    input  wire minv_pkg::cmd_t     cmd,
    output minv_pkg::status_t       status,
    output minv_pkg::out_item_t     result
);
    import minv_pkg::*;

    logic [WIDTH-1:0] m_reg, r0_reg, r1_reg, a_reg;
    logic [WIDTH:0]   t0_reg, t1_reg;      // signed coefficients, |t| <= m
    logic [WIDTH-1:0] dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    out_item_t        result_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] rem_shift;
    logic [WIDTH:0]   prod;
    logic [WIDTH:0]   tn;
    logic [WIDTH:0]   t_fix;
    logic             has_inv;

    assign rem_shift = {rem_reg[WIDTH-2:0], dvd_reg[WIDTH-1]};
    assign trial = {rem_reg[WIDTH-1], rem_shift} - {1'b0, dvs_reg};
    // only the low WIDTH+1 bits of q * t1 matter, since |tn| <= m
    assign prod = $signed({1'b0, quo_reg}) * $signed(t1_reg);
    assign tn = t0_reg - prod;
    assign t_fix = t0_reg[WIDTH] ? (t0_reg + {1'b0, m_reg}) : t0_reg;
    assign has_inv = (m_reg != '0) && (r0_reg == WIDTH'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= in_item.value[WIDTH-1:0];
            m_reg <= in_item.modulus[WIDTH-1:0];
        end
        if (cmd.div_start)
        begin
            dvd_reg <= cmd.reduce_done ? a_reg : r0_reg;
            dvs_reg <= cmd.reduce_done ? m_reg : r1_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CNT_W'(WIDTH);
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (!trial[WIDTH])
            begin
                rem_reg <= trial[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
        if (cmd.reduce_done && !cmd.div_start)
        begin
            r0_reg <= m_reg;
            r1_reg <= rem_reg;
            t0_reg <= '0;
            t1_reg <= (WIDTH+1)'(1);
        end
        if (cmd.update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            t0_reg <= t1_reg;
            t1_reg <= tn;
        end
        if (cmd.finish)
        begin
            result_reg.exists  <= has_inv;
            result_reg.inverse <= (has_inv && (m_reg != WIDTH'(1)))
                                  ? 32'(t_fix[WIDTH-1:0]) : '0;
        end
    end

    assign status.m_zero   = (m_reg == '0);
    assign status.r1_zero  = (r1_reg == '0);
    assign status.div_last = (cnt_reg == CNT_W'(1));
    assign result = result_reg;
endmodule
`default_nettype wire

>>> hw/rtl/minv_ctrl.sv
// Controller state machine of the modular inverse block: sequences the
// reduction, Euclid rounds and result handshake. Depends on minv_pkg.
`default_nettype none
module minv_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire minv_pkg::status_t status,
    output minv_pkg::cmd_t         cmd
);
    import minv_pkg::*;

    state_t state_reg, state_next;
    logic   reduce_reg, reduce_next;   // divider is doing the initial a mod m

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            reduce_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            reduce_reg <= reduce_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        reduce_next = reduce_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // m == 0: skip straight to the no-inverse result
                if (status.m_zero)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.div_start   = 1'b1;
                    cmd.reduce_done = 1'b1;
                    reduce_next     = 1'b1;
                    state_next      = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = reduce_reg ? ST_CHECK : ST_UPDATE;
            end
            ST_CHECK:
            begin
                if (reduce_reg)
                begin
                    cmd.reduce_done = 1'b1;   // set r0/r1/t0/t1
                    reduce_next     = 1'b0;
                end
                else if (status.r1_zero)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/modular_inverse_top.sv
// Top level of the modular inverse block. Instantiates minv_ctrl and
// minv_datapath; depends on minv_pkg.
//
// Computes value^-1 mod modulus by the extended Euclidean algorithm, one item
// at a time. Each item with a nonzero modulus takes one reduction (a mod m)
// plus one round per Euclid quotient; every division runs on one shared
// bit-serial restoring divider. A new item is taken only after the result
// transfers.
`default_nettype none
module modular_inverse_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire minv_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output minv_pkg::out_item_t      out_data
);
    import minv_pkg::*;

    cmd_t    cmd;
    status_t status;

    minv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    minv_datapath u_dp (
        .clk     (clk),
        .in_item (in_data),
        .cmd     (cmd),
        .status  (status),
        .result  (out_data)
    );
endmodule
`default_nettype wire

>>> hw/rtl/minv_checker.sv
// Port-level checker for modular_inverse_top, bound to the top level.
// Depends on minv_pkg.
`default_nettype none
module minv_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire minv_pkg::out_item_t out_data
);
    import minv_pkg::*;

    // never take input while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open during output");

    // a result offered stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped");

    // no inverse means zero inverse
    a_zero_inv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.exists |-> out_data.inverse == 32'd0)
        else $error("nonzero inverse without existence");

    // accepted input blocks the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid)
        else $error("accept did not start work");
endmodule

bind modular_inverse_top minv_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
